@@ hw/rtl/bucketed_hash_table_insert_unit_assert.svh @@
// ----------------------------------------------------------------------------
// bucketed hash table insert unit: assertion macros
// shared concurrent assertion forms, clocked on clk_i and off in reset
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_TABLE_INSERT_UNIT_ASSERT_SVH
`define BUCKETED_HASH_TABLE_INSERT_UNIT_ASSERT_SVH

// same-cycle implication
`define BHTI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bhti assertion failed");

// next-cycle implication
`define BHTI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bhti assertion failed");

`endif

@@ hw/rtl/bhti_pkg.sv @@
// ----------------------------------------------------------------------------
// bhti_pkg
// types and constants of the bucketed hash table insert unit
// ----------------------------------------------------------------------------
package bhti_pkg;

  localparam int IndexBitsDef  = 12;
  localparam int ProbeLimitDef = 19;
  localparam int HashShiftDef  = 10;

  localparam int THR_W        = 5;
  localparam int FILE_NUM_W   = 17;
  localparam int OFFSET_W     = 27;
  localparam int WORD_W       = 64;
  localparam int STATUS_W     = 2;
  localparam int PROBE_SLOT_W = 5;
  localparam int ENTRY_W      = 13;

  localparam logic [THR_W-1:0] THR_RESET = 5'd11;

  typedef enum logic [STATUS_W-1:0] {
    BHTI_ST_STORED = 2'd0,
    BHTI_ST_DEEP   = 2'd1,
    BHTI_ST_FULL   = 2'd2
  } bhti_status_e;

  typedef enum logic [1:0] {
    BHTI_CLEAR,
    BHTI_IDLE,
    BHTI_PROBE
  } bhti_state_e;

  typedef struct packed {
    logic [WORD_W-1:0]     digest_word0;
    logic [WORD_W-1:0]     digest_word1;
    logic [WORD_W-1:0]     digest_word2;
    logic [WORD_W-1:0]     digest_word3;
    logic [FILE_NUM_W-1:0] file_number;
    logic [OFFSET_W-1:0]   byte_offset;
  } bhti_in_t;

  typedef struct packed {
    bhti_status_e            status;
    logic [PROBE_SLOT_W-1:0] probe_slot;
    logic [ENTRY_W-1:0]      entry_index;
  } bhti_out_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_val;
  } bhti_occ_ctl_t;

endpackage

@@ hw/rtl/bhti_occ_mem.sv @@
// ----------------------------------------------------------------------------
// bhti_occ_mem
// occupancy map: one bit per table entry, registered read port
// ----------------------------------------------------------------------------
module bhti_occ_mem #(
  parameter int DEPTH  = 4114,
  parameter int ADDR_W = 13
) (
  input  logic                   clk_i,
  input  bhti_pkg::bhti_occ_ctl_t ctl_i,
  input  logic [ADDR_W-1:0]      rd_addr_i,
  input  logic [ADDR_W-1:0]      wr_addr_i,
  output logic                   rd_data_o
);
  import bhti_pkg::*;

  logic mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= ctl_i.wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

@@ hw/rtl/bhti_entry_mem.sv @@
// ----------------------------------------------------------------------------
// bhti_entry_mem
// entry store: digest, file number and offset of each table entry
// ----------------------------------------------------------------------------
module bhti_entry_mem #(
  parameter int DEPTH  = 4114,
  parameter int ADDR_W = 13
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  bhti_pkg::bhti_in_t wr_data_i
);
  import bhti_pkg::*;

  bhti_in_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

endmodule

@@ hw/rtl/bhti_seq.sv @@
// ----------------------------------------------------------------------------
// bhti_seq
// probe sequencer: clears the map, walks the probe window, writes the entry
// ----------------------------------------------------------------------------
`include "bucketed_hash_table_insert_unit_assert.svh"

module bhti_seq #(
  parameter int INDEX_BITS  = 12,
  parameter int PROBE_LIMIT = 19,
  parameter int HASH_SHIFT  = 10,
  parameter int DEPTH       = 4114,
  parameter int ADDR_W      = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  bhti_pkg::bhti_in_t            item_i,
  output logic                          busy,
  output logic                          done_o,
  output bhti_pkg::bhti_out_t           result_o,
  input  logic [bhti_pkg::THR_W-1:0]    thr_i,
  output bhti_pkg::bhti_occ_ctl_t       occ_ctl_o,
  output logic [ADDR_W-1:0]             occ_rd_addr_o,
  output logic [ADDR_W-1:0]             occ_wr_addr_o,
  input  logic                          occ_rd_data_i,
  output logic                          ent_wr_en_o,
  output logic [ADDR_W-1:0]             ent_wr_addr_o,
  output bhti_pkg::bhti_in_t            ent_wr_data_o
);
  import bhti_pkg::*;

  localparam int SLOT_W = $clog2(PROBE_LIMIT + 1);
  localparam int CMP_W  = (SLOT_W > THR_W) ? SLOT_W : THR_W;
  localparam int SX_W   = (SLOT_W > PROBE_SLOT_W) ? SLOT_W : PROBE_SLOT_W;
  localparam int EX_W   = (ADDR_W > ENTRY_W) ? ADDR_W : ENTRY_W;

  bhti_state_e       state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] home_q, home_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  bhti_in_t          item_q, item_d;
  logic              done_q, done_d;
  bhti_out_t         result_q, result_d;

  logic [31:0]           hval;
  logic [INDEX_BITS-1:0] home_c;
  logic [ADDR_W-1:0]     addr_inc;
  logic                  deep;
  logic [SX_W-1:0]       slot_x;
  logic [SX_W-1:0]       limit_x;
  logic [EX_W-1:0]       addr_x;
  logic [EX_W-1:0]       home_x;

  assign hval     = item_i.digest_word0[31:0] >> HASH_SHIFT;
  assign home_c   = {hval[INDEX_BITS-1:3], 3'b000};
  assign addr_inc = addr_q + ADDR_W'(1);
  assign deep     = CMP_W'(slot_q) >= CMP_W'(thr_i);
  assign slot_x   = SX_W'(slot_q);
  assign limit_x  = SX_W'(PROBE_LIMIT);
  assign addr_x   = EX_W'(addr_q);
  assign home_x   = EX_W'(home_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BHTI_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    addr_q   <= addr_d;
    home_q   <= home_d;
    item_q   <= item_d;
    result_q <= result_d;
  end

  always_comb begin
    state_d       = state_q;
    slot_d        = slot_q;
    addr_d        = addr_q;
    home_d        = home_q;
    clr_d         = clr_q;
    item_d        = item_q;
    done_d        = 1'b0;
    result_d      = result_q;
    occ_ctl_o     = '0;
    occ_rd_addr_o = addr_inc;
    occ_wr_addr_o = addr_q;
    ent_wr_en_o   = 1'b0;
    case (state_q)
      BHTI_CLEAR: begin
        occ_ctl_o.wr_en  = 1'b1;
        occ_ctl_o.wr_val = 1'b0;
        occ_wr_addr_o    = clr_q;
        clr_d            = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = BHTI_IDLE;
        end
      end
      BHTI_IDLE: begin
        if (start) begin
          item_d          = item_i;
          home_d          = ADDR_W'(home_c);
          addr_d          = ADDR_W'(home_c);
          slot_d          = '0;
          occ_ctl_o.rd_en = 1'b1;
          occ_rd_addr_o   = ADDR_W'(home_c);
          state_d         = BHTI_PROBE;
        end
      end
      BHTI_PROBE: begin
        if (!occ_rd_data_i) begin
          occ_ctl_o.wr_en      = 1'b1;
          occ_ctl_o.wr_val     = 1'b1;
          ent_wr_en_o          = 1'b1;
          done_d               = 1'b1;
          result_d.status      = deep ? BHTI_ST_DEEP : BHTI_ST_STORED;
          result_d.probe_slot  = slot_x[PROBE_SLOT_W-1:0];
          result_d.entry_index = addr_x[ENTRY_W-1:0];
          state_d              = BHTI_IDLE;
        end else if (slot_q == SLOT_W'(PROBE_LIMIT - 1)) begin
          done_d               = 1'b1;
          result_d.status      = BHTI_ST_FULL;
          result_d.probe_slot  = limit_x[PROBE_SLOT_W-1:0];
          result_d.entry_index = home_x[ENTRY_W-1:0];
          state_d              = BHTI_IDLE;
        end else begin
          slot_d          = slot_q + SLOT_W'(1);
          addr_d          = addr_inc;
          occ_ctl_o.rd_en = 1'b1;
        end
      end
      default: begin
        state_d = BHTI_CLEAR;
      end
    endcase
  end

  assign busy          = state_q != BHTI_IDLE;
  assign done_o        = done_q;
  assign result_o      = result_q;
  assign ent_wr_addr_o = addr_q;
  assign ent_wr_data_o = item_q;

  `BHTI_ASSERT_NOW(a_done_after_probe, done_q, $past(state_q == BHTI_PROBE))
  `BHTI_ASSERT_NOW(a_occ_wr_state, occ_ctl_o.wr_en, state_q == BHTI_CLEAR || state_q == BHTI_PROBE)
  `BHTI_ASSERT_NEXT(a_start_probes, state_q == BHTI_IDLE && start, state_q == BHTI_PROBE)
  `BHTI_ASSERT_NOW(a_slot_in_window, state_q == BHTI_PROBE, slot_q < SLOT_W'(PROBE_LIMIT))

endmodule

@@ hw/rtl/bucketed_hash_table_insert_unit.sv @@
// ----------------------------------------------------------------------------
// bucketed_hash_table_insert_unit
// linear probe insert of digest records into a bucketed hash table
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+--------------------------
// insert   | in        | start / busy            | item_i   (bhti_in_t)
// result   | out       | done_o strobe           | result_o (bhti_out_t)
// config   | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (threshold)
//
// an item makes one occupancy map read per probed slot; the result strobe
// is registered; after reset a clearing pass over all 2^INDEX_BITS +
// PROBE_LIMIT - 1 entries (4114 by default) sweeps the occupancy map with
// busy high
// results are not held off by the receiver; config is always ready
// ----------------------------------------------------------------------------
module bucketed_hash_table_insert_unit #(
  parameter int INDEX_BITS  = bhti_pkg::IndexBitsDef,
  parameter int PROBE_LIMIT = bhti_pkg::ProbeLimitDef,
  parameter int HASH_SHIFT  = bhti_pkg::HashShiftDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  bhti_pkg::bhti_in_t         item_i,
  output logic                       done_o,
  output bhti_pkg::bhti_out_t        result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bhti_pkg::THR_W-1:0] cfg_data_i
);
  import bhti_pkg::*;

  localparam int DEPTH  = (1 << INDEX_BITS) + PROBE_LIMIT - 1;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [THR_W-1:0]  thr_q;
  bhti_occ_ctl_t     occ_ctl;
  logic [ADDR_W-1:0] occ_rd_addr;
  logic [ADDR_W-1:0] occ_wr_addr;
  logic              occ_rd_data;
  logic              ent_wr_en;
  logic [ADDR_W-1:0] ent_wr_addr;
  bhti_in_t          ent_wr_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  bhti_seq #(
    .INDEX_BITS  (INDEX_BITS),
    .PROBE_LIMIT (PROBE_LIMIT),
    .HASH_SHIFT  (HASH_SHIFT),
    .DEPTH       (DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .item_i        (item_i),
    .busy          (busy),
    .done_o        (done_o),
    .result_o      (result_o),
    .thr_i         (thr_q),
    .occ_ctl_o     (occ_ctl),
    .occ_rd_addr_o (occ_rd_addr),
    .occ_wr_addr_o (occ_wr_addr),
    .occ_rd_data_i (occ_rd_data),
    .ent_wr_en_o   (ent_wr_en),
    .ent_wr_addr_o (ent_wr_addr),
    .ent_wr_data_o (ent_wr_data)
  );

  bhti_occ_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_occ_mem (
    .clk_i     (clk_i),
    .ctl_i     (occ_ctl),
    .rd_addr_i (occ_rd_addr),
    .wr_addr_i (occ_wr_addr),
    .rd_data_o (occ_rd_data)
  );

  bhti_entry_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_entry_mem (
    .clk_i     (clk_i),
    .wr_en_i   (ent_wr_en),
    .wr_addr_i (ent_wr_addr),
    .wr_data_i (ent_wr_data)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: bucketed hash table insert unit testbench
// drives digest inserts through the start/busy port and threshold writes
// through the config channel, mirrors the occupancy map in a class and
// checks every result strobe field by field against the predicted slot,
// entry and status; directed fill of one bucket to a full window first,
// then random phases that cluster inserts on a few neighbouring buckets
// ----------------------------------------------------------------------------
module tb_top;
  import bhti_pkg::*;

  localparam int ProbeLimit = ProbeLimitDef;
  localparam int TableDepth = (1 << IndexBitsDef) + ProbeLimitDef - 1;
  localparam int HomeMask   = ((1 << IndexBitsDef) - 1) & ~7;
  localparam int BucketLo   = HashShiftDef + 3;
  localparam int BucketHi   = HashShiftDef + IndexBitsDef - 1;
  localparam int Buckets    = 1 << (IndexBitsDef - 3);
  localparam int MaxFileNum = 99999;

  class probe_table_model;
    bit               occupied [TableDepth];
    logic [THR_W-1:0] warn_thr;
    bhti_out_t        pending [$];
    int               mismatches;

    function new();
      warn_thr   = THR_RESET;
      mismatches = 0;
      foreach (occupied[i]) occupied[i] = 1'b0;
    endfunction

    function void note_insert(bhti_in_t it);
      int        home;
      int        slot;
      int        entry;
      bhti_out_t want;
      home = int'((it.digest_word0[31:0] >> HashShiftDef) & HomeMask);
      slot = 0;
      while (slot < ProbeLimit && occupied[home + slot]) slot++;
      if (slot >= ProbeLimit) begin
        want.status = BHTI_ST_FULL;
        entry = home;
      end else begin
        entry = home + slot;
        occupied[entry] = 1'b1;
        want.status = (slot >= int'(warn_thr)) ? BHTI_ST_DEEP : BHTI_ST_STORED;
      end
      want.probe_slot  = slot[PROBE_SLOT_W-1:0];
      want.entry_index = entry[ENTRY_W-1:0];
      pending.push_back(want);
    endfunction

    function void check_result(bhti_out_t got);
      bhti_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d entry=%0d",
                 $time, got.status, got.probe_slot, got.entry_index);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.probe_slot !== want.probe_slot) begin
        $display("%0t: probe_slot expected %0d actual %0d",
                 $time, want.probe_slot, got.probe_slot);
        mismatches++;
      end
      if (got.entry_index !== want.entry_index) begin
        $display("%0t: entry_index expected %0d actual %0d",
                 $time, want.entry_index, got.entry_index);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  bhti_in_t         item_i = '0;
  logic             done_o;
  bhti_out_t        result_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i = '0;

  probe_table_model hash_model = new();

  bucketed_hash_table_insert_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) hash_model.check_result(result_o);
  end

  // random record; a bucket of -1 leaves the home index random
  function automatic bhti_in_t make_item(int bucket);
    bhti_in_t it;
    it.digest_word0 = {$urandom, $urandom};
    it.digest_word1 = {$urandom, $urandom};
    it.digest_word2 = {$urandom, $urandom};
    it.digest_word3 = {$urandom, $urandom};
    if (bucket >= 0) it.digest_word0[BucketHi:BucketLo] = bucket[BucketHi-BucketLo:0];
    it.file_number = FILE_NUM_W'($urandom_range(0, MaxFileNum));
    it.byte_offset = OFFSET_W'($urandom);
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_insert(input bhti_in_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    hash_model.note_insert(it);
    @(negedge clk_i);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (hash_model.pending.size() != 0 || busy);
    @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    hash_model.warn_thr = thr;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    bhti_in_t         it;
    logic [THR_W-1:0] thr;
    int               hot_base;
    bit               gaps_on;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // extremes of every field, top bucket and bucket zero
    it.digest_word0 = '1;
    it.digest_word1 = '1;
    it.digest_word2 = '1;
    it.digest_word3 = '1;
    it.file_number  = FILE_NUM_W'(MaxFileNum);
    it.byte_offset  = '1;
    push_insert(it);
    push_insert('0);
    // duplicate digest lands in the next slot
    push_insert('0);
    // fill bucket zero through the deep slots, then overflow the window twice
    repeat (ProbeLimit - 2) push_insert(make_item(0));
    repeat (2) push_insert(make_item(0));
    // next bucket overlaps the full window
    wait_idle();
    write_threshold('0);
    push_insert(make_item(1));
    wait_idle();
    write_threshold('1);
    push_insert(make_item(1));

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       thr = THR_W'(ProbeLimit);
        1:       thr = '1;
        2:       thr = '0;
        7:       thr = THR_RESET;
        default: thr = THR_W'($urandom_range(0, 31));
      endcase
      wait_idle();
      write_threshold(thr);
      hot_base = $urandom_range(0, Buckets - 4);
      gaps_on  = (phase < 7);
      for (int n = 0; n < 125; n++) begin
        if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 17));
        if ($urandom_range(0, 9) < 7) push_insert(make_item(hot_base + $urandom_range(0, 3)));
        else push_insert(make_item(-1));
      end
    end

    wait_idle();
    repeat (ProbeLimit + 4) @(posedge clk_i);
    if (hash_model.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
